// File: rtl/heartbeat_rate_detector_assert.svh
// Assertion macros used by the checker file of the heartbeat rate detector.
`ifndef HEARTBEAT_RATE_DETECTOR_ASSERT_SVH
`define HEARTBEAT_RATE_DETECTOR_ASSERT_SVH

// Check that cons holds in the cycle after ante.
`define HRD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("heartbeat_rate_detector: next-cycle check failed");

// Check that cons holds in the same cycle as ante.
`define HRD_ASSERT_SAME(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("heartbeat_rate_detector: same-cycle check failed");

`endif

// File: rtl/hrd_pkg.sv
`default_nettype none
package hrd_pkg;

	// Defaults for the top level parameters
	localparam int MAX_BEATS_DEF   = 256;
	localparam int SAMPLE_BITS_DEF = 10;

	// Fixed field widths
	localparam int TIME_W      = 32;
	localparam int THRESH_W    = 10;
	localparam int RATE_W      = 8;
	localparam int REFR_W      = 16;
	localparam int COUNT_OUT_W = 9;
	localparam int MEAN_W      = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// Beats per minute numerator, in milliseconds
	localparam int RATE_NUM   = 60000;
	localparam int RATE_NUM_W = 16;

	// Baseline filter weights: 0.9 -> 230/256, 0.1 -> 26/256
	localparam int BASE_KEEP = 230;
	localparam int BASE_GAIN = 256 * 26;

	// Command queue depth between front and back
	localparam int QDEPTH = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PEAK_THRESHOLD,
		REG_RATE_LOW,
		REG_RATE_HIGH,
		REG_REFRACTORY
	} cfg_reg_t;

	typedef struct packed {
		logic [THRESH_W-1:0] peak_threshold;
		logic [RATE_W-1:0]   rate_low;
		logic [RATE_W-1:0]   rate_high;
		logic [REFR_W-1:0]   refractory_ms;
	} hrd_cfg_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_CLEAR,
		OP_BEAT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t             op;
		logic [TIME_W-1:0]   elapsed;
	} hrd_cmd_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RATE,
		B_MEAN,
		B_DONE
	} back_state_t;

endpackage
`default_nettype wire

// File: rtl/hrd_front.sv
`default_nettype none
module hrd_front #(
	parameter int SAMPLE_BITS = hrd_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        action,
	input  wire logic [SAMPLE_BITS-1:0]      sample,
	input  wire logic [hrd_pkg::TIME_W-1:0]  time_ms,
	input  wire logic                        enable,
	input  wire hrd_pkg::hrd_cfg_t           cfg,
	output logic                             push,
	output hrd_pkg::hrd_cmd_t                cmd,
	input  wire logic                        q_full
);

	localparam int BW = SAMPLE_BITS + 8;
	localparam int PW = SAMPLE_BITS + 17;
	localparam int CW = BW + 2;

	logic                        valid_s1;
	logic                        action_s1;
	logic [SAMPLE_BITS-1:0]      sample_s1;
	logic [hrd_pkg::TIME_W-1:0]  time_s1;
	logic                        enable_s1;

	logic [BW-1:0]               base_q;
	logic [hrd_pkg::TIME_W-1:0]  last_beat_q;

	logic [PW-1:0]               base_prod;
	logic [BW-1:0]               base_next;
	logic                        peak;
	logic [hrd_pkg::TIME_W-1:0]  elapsed;
	logic                        beat;
	logic                        in_acc;

	// Take a new beat whenever the stage is empty or draining into the queue
	assign in_stall = valid_s1 && q_full;
	assign in_acc   = in_valid && !in_stall;
	assign push     = valid_s1 && !q_full;

	// Baseline filter and peak test against the updated baseline
	always_comb begin
		base_prod = PW'(base_q) * PW'(hrd_pkg::BASE_KEEP)
			+ PW'(sample_s1) * PW'(hrd_pkg::BASE_GAIN);
		base_next = BW'(base_prod >> 8);
		peak      = CW'({sample_s1, 8'h00}) >
			(CW'(base_next) + CW'({cfg.peak_threshold, 8'h00}));
		elapsed   = time_s1 - last_beat_q;
		beat      = peak && (elapsed > hrd_pkg::TIME_W'(cfg.refractory_ms));
	end

	// Classify the item for the back end
	always_comb begin
		cmd.elapsed = elapsed;
		if (action_s1) begin
			cmd.op = hrd_pkg::OP_CLEAR;
		end else if (enable_s1 && beat) begin
			cmd.op = hrd_pkg::OP_BEAT;
		end else begin
			cmd.op = hrd_pkg::OP_HOLD;
		end
	end

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_s1 <= action;
			sample_s1 <= sample;
			time_s1   <= time_ms;
			enable_s1 <= enable;
		end
	end

	// Advance baseline and last beat time as an enabled, non-clear item leaves for the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			last_beat_q <= '0;
		end else if (push && !action_s1 && enable_s1) begin
			base_q <= base_next;
			if (beat) begin
				last_beat_q <= time_s1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/hrd_queue.sv
`default_nettype none
module hrd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire hrd_pkg::hrd_cmd_t cmd_in,
	output logic                   full,
	input  wire logic              pop,
	output hrd_pkg::hrd_cmd_t      cmd_out,
	output logic                   empty
);

	localparam int PTR_W = (hrd_pkg::QDEPTH > 1) ? $clog2(hrd_pkg::QDEPTH) : 1;
	localparam int CNT_W = $clog2(hrd_pkg::QDEPTH + 1);

	hrd_pkg::hrd_cmd_t   entry_q [hrd_pkg::QDEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    cnt_q;

	assign full    = (cnt_q == CNT_W'(hrd_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign cmd_out = entry_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(hrd_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(hrd_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/hrd_div.sv
`default_nettype none
module hrd_div #(
	parameter int QW = 25,
	parameter int VW = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [QW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic [QW-1:0]      quotient
);

	localparam int CNT_W = (QW > 1) ? $clog2(QW) : 1;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [VW-1:0]     rem_q;
	logic [QW-1:0]     quo_q;
	logic [VW-1:0]     div_q;

	logic [VW:0]       shifted;
	logic [VW:0]       diff;
	logic              fits;

	assign done     = done_q;
	assign quotient = quo_q;

	// One restoring step: bring in the next dividend bit, subtract if it fits
	always_comb begin
		shifted = {rem_q, quo_q[QW-1]};
		diff    = shifted - {1'b0, div_q};
		fits    = (shifted >= {1'b0, div_q});
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? VW'(diff) : VW'(shifted);
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

endmodule
`default_nettype wire

// File: rtl/hrd_back.sv
`default_nettype none
module hrd_back #(
	parameter int MAX_BEATS = hrd_pkg::MAX_BEATS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire hrd_pkg::hrd_cfg_t                 cfg,
	input  wire hrd_pkg::hrd_cmd_t                 cmd,
	input  wire logic                              q_empty,
	output logic                                   pop,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [hrd_pkg::RATE_W-1:0]             beat_rate,
	output logic [hrd_pkg::COUNT_OUT_W-1:0]        beat_count,
	output logic [hrd_pkg::MEAN_W-1:0]             mean_rate_x256
);

	localparam int CW    = $clog2(MAX_BEATS + 1);
	localparam int SUM_W = hrd_pkg::RATE_W + CW;
	localparam int QW    = (SUM_W + 8 > hrd_pkg::RATE_NUM_W) ? SUM_W + 8 : hrd_pkg::RATE_NUM_W;
	localparam int VW    = hrd_pkg::TIME_W;

	hrd_pkg::back_state_t state_q, state_d;

	logic [SUM_W-1:0]              sum_q;
	logic [CW-1:0]                 count_q;
	logic [hrd_pkg::MEAN_W-1:0]    mean_q;
	logic [hrd_pkg::RATE_W-1:0]    rate_q;

	logic                          out_valid_q;
	logic [hrd_pkg::RATE_W-1:0]    out_rate_q;
	logic [hrd_pkg::COUNT_OUT_W-1:0] out_count_q;
	logic [hrd_pkg::MEAN_W-1:0]    out_mean_q;

	logic                          div_start;
	logic                          div_sel_rate;
	logic [QW-1:0]                 div_dividend;
	logic [VW-1:0]                 div_divisor;
	logic                          div_done;
	logic [QW-1:0]                 div_quo;

	logic                          in_range;
	logic                          room;
	logic [SUM_W-1:0]              sum_new;
	logic [CW-1:0]                 count_new;
	logic                          out_free;
	logic                          out_load;

	assign out_valid      = out_valid_q;
	assign beat_rate      = out_rate_q;
	assign beat_count     = out_count_q;
	assign mean_rate_x256 = out_mean_q;

	// Rate check and running totals with the fresh quotient
	always_comb begin
		in_range  = (div_quo >= QW'(cfg.rate_low)) && (div_quo <= QW'(cfg.rate_high));
		room      = (count_q < CW'(MAX_BEATS));
		sum_new   = sum_q + SUM_W'(div_quo[hrd_pkg::RATE_W-1:0]);
		count_new = count_q + 1'b1;
		out_free  = !out_valid_q || !out_stall;
	end

	// Divider operands: beat interval first, then the mean
	always_comb begin
		if (div_sel_rate) begin
			div_dividend = QW'(hrd_pkg::RATE_NUM);
			div_divisor  = cmd.elapsed;
		end else begin
			div_dividend = QW'({sum_new, 8'h00});
			div_divisor  = VW'(count_new);
		end
	end

	hrd_div #(
		.QW(QW),
		.VW(VW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.done(div_done),
		.quotient(div_quo)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			hrd_pkg::B_IDLE: begin
				if (!q_empty) begin
					state_d = (cmd.op == hrd_pkg::OP_BEAT) ? hrd_pkg::B_RATE : hrd_pkg::B_DONE;
				end
			end
			hrd_pkg::B_RATE: begin
				if (div_done) begin
					state_d = (in_range && room) ? hrd_pkg::B_MEAN : hrd_pkg::B_DONE;
				end
			end
			hrd_pkg::B_MEAN: begin
				if (div_done) begin
					state_d = hrd_pkg::B_DONE;
				end
			end
			hrd_pkg::B_DONE: begin
				if (out_free) begin
					state_d = hrd_pkg::B_IDLE;
				end
			end
			default: state_d = hrd_pkg::B_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		pop          = 1'b0;
		div_start    = 1'b0;
		div_sel_rate = 1'b0;
		out_load     = 1'b0;
		case (state_q)
			hrd_pkg::B_IDLE: begin
				div_sel_rate = 1'b1;
				if (!q_empty) begin
					pop       = 1'b1;
					div_start = (cmd.op == hrd_pkg::OP_BEAT);
				end
			end
			hrd_pkg::B_RATE: begin
				div_start = div_done && in_range && room;
			end
			hrd_pkg::B_MEAN: begin
				div_start = 1'b0;
			end
			hrd_pkg::B_DONE: begin
				out_load = out_free;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hrd_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Session totals and cached mean
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
			mean_q  <= '0;
			rate_q  <= '0;
		end else begin
			if (pop) begin
				rate_q <= '0;
				if (cmd.op == hrd_pkg::OP_CLEAR) begin
					sum_q   <= '0;
					count_q <= '0;
					mean_q  <= '0;
				end
			end
			if ((state_q == hrd_pkg::B_RATE) && div_done && in_range) begin
				rate_q <= div_quo[hrd_pkg::RATE_W-1:0];
				if (room) begin
					sum_q   <= sum_new;
					count_q <= count_new;
				end
			end
			if ((state_q == hrd_pkg::B_MEAN) && div_done) begin
				mean_q <= hrd_pkg::MEAN_W'(div_quo);
			end
		end
	end

	// Output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rate_q  <= rate_q;
			out_count_q <= hrd_pkg::COUNT_OUT_W'(count_q);
			out_mean_q  <= mean_q;
		end
	end

endmodule
`default_nettype wire

// File: rtl/heartbeat_rate_detector.sv
// Heartbeat rate detector.
// Input channel (in_valid / in_stall): one beat carries action, sample, time_ms
// and enable. Output channel (out_valid / out_stall): exactly one result beat per
// input beat, in order: beat_rate, beat_count and mean_rate_x256.
// Config channel (cfg_valid / cfg_ready, always ready): cfg_index selects
// peak_threshold, rate_low, rate_high or refractory_ms; write only while idle.
// A front stage updates the baseline and classifies each sample, then hands a
// command to a two-entry queue. The back end runs a shared radix-2 divider,
// one quotient bit per cycle, for 60000/interval and then for the mean. The
// quotient width is 25 at the default capacity. An accepted beat runs both
// divisions, a rejected peak only the first, and a session clear, disabled
// sample or non-peak none.
// The front keeps accepting while the back end works until the queue fills.
// A stalled result is held in the output register; the back end then waits.
// Reset clears the baseline, last beat time, totals and all valids, and loads
// the register defaults (20, 50, 150, 300).
`default_nettype none
module heartbeat_rate_detector #(
	parameter int MAX_BEATS   = hrd_pkg::MAX_BEATS_DEF,
	parameter int SAMPLE_BITS = hrd_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic                                 action,
	input  wire logic [SAMPLE_BITS-1:0]               sample,
	input  wire logic [hrd_pkg::TIME_W-1:0]           time_ms,
	input  wire logic                                 enable,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [hrd_pkg::RATE_W-1:0]                beat_rate,
	output logic [hrd_pkg::COUNT_OUT_W-1:0]           beat_count,
	output logic [hrd_pkg::MEAN_W-1:0]                mean_rate_x256,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [hrd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [hrd_pkg::CFG_DATA_W-1:0]       cfg_data
);

	hrd_pkg::hrd_cfg_t cfg_q;
	hrd_pkg::hrd_cmd_t push_cmd;
	hrd_pkg::hrd_cmd_t pop_cmd;
	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;

	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peak_threshold <= hrd_pkg::THRESH_W'(20);
			cfg_q.rate_low       <= hrd_pkg::RATE_W'(50);
			cfg_q.rate_high      <= hrd_pkg::RATE_W'(150);
			cfg_q.refractory_ms  <= hrd_pkg::REFR_W'(300);
		end else if (cfg_valid && cfg_ready) begin
			case (hrd_pkg::cfg_reg_t'(cfg_index))
				hrd_pkg::REG_PEAK_THRESHOLD: begin
					cfg_q.peak_threshold <= cfg_data[hrd_pkg::THRESH_W-1:0];
				end
				hrd_pkg::REG_RATE_LOW: begin
					cfg_q.rate_low <= cfg_data[hrd_pkg::RATE_W-1:0];
				end
				hrd_pkg::REG_RATE_HIGH: begin
					cfg_q.rate_high <= cfg_data[hrd_pkg::RATE_W-1:0];
				end
				hrd_pkg::REG_REFRACTORY: begin
					cfg_q.refractory_ms <= cfg_data[hrd_pkg::REFR_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	hrd_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.sample(sample),
		.time_ms(time_ms),
		.enable(enable),
		.cfg(cfg_q),
		.push(push),
		.cmd(push_cmd),
		.q_full(q_full)
	);

	hrd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.cmd_in(push_cmd),
		.full(q_full),
		.pop(pop),
		.cmd_out(pop_cmd),
		.empty(q_empty)
	);

	hrd_back #(
		.MAX_BEATS(MAX_BEATS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.cmd(pop_cmd),
		.q_empty(q_empty),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.beat_rate(beat_rate),
		.beat_count(beat_count),
		.mean_rate_x256(mean_rate_x256)
	);

endmodule
`default_nettype wire

// File: rtl/hrd_checker.sv
`default_nettype none
`include "heartbeat_rate_detector_assert.svh"
module hrd_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  wire logic [hrd_pkg::RATE_W-1:0]      beat_rate,
	input  wire logic [hrd_pkg::COUNT_OUT_W-1:0] beat_count,
	input  wire logic [hrd_pkg::MEAN_W-1:0]      mean_rate_x256
);

	// A stalled result beat stays and holds its payload
	`HRD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(beat_rate) && $stable(beat_count) && $stable(mean_rate_x256))
	// A reported rate means at least one beat is counted
	`HRD_ASSERT_SAME(a_rate_counted, clk, arst_n, out_valid && (beat_rate != '0), beat_count != '0)
	// An empty session has no mean
	`HRD_ASSERT_SAME(a_empty_mean, clk, arst_n, out_valid && (beat_count == '0), mean_rate_x256 == '0)

endmodule

bind heartbeat_rate_detector hrd_checker u_hrd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.beat_rate(beat_rate),
	.beat_count(beat_count),
	.mean_rate_x256(mean_rate_x256)
);
`default_nettype wire
